// ===== src/uniform_grid_resampler_defines.svh =====
// Assertion macros used by the resampler top-level source.
`ifndef UNIFORM_GRID_RESAMPLER_DEFINES_SVH
`define UNIFORM_GRID_RESAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define UGR_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UGR_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== src/ugr_pkg.sv =====
package ugr_pkg;

   localparam int MAX_VALUES_DEF = 4;
   localparam int MAX_GAP_DEF    = 16;
   localparam int INDEX_BITS_DEF = 20;

   localparam int VALUE_FIELDS = 4;
   localparam int TIME_W       = 32;
   localparam int GRID_W       = 20;
   localparam int STRIDE_W     = 11;
   localparam int NUMV_W       = 3;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 11;

   localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(1);
   localparam logic [NUMV_W-1:0]   NUMV_RST   = NUMV_W'(4);

   typedef enum logic {CMD_DATA = 1'b0, CMD_FLUSH = 1'b1} command_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_STEP = 2'd1,
      ST_BACKWARD  = 2'd2,
      ST_GAP       = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRIDE     = 1'b0,
      CSR_NUM_VALUES = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      ROWS_NONE   = 2'd0,
      ROWS_ORIGIN = 2'd1,
      ROWS_STEP   = 2'd2
   } rows_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_STEP, S_INDEX, S_IDXW, S_HELD, S_ADV, S_MID, S_DONE, S_ERR, S_FLUSH
   } state_type;

   // Commands from the sequencer to every column lane.
   typedef struct packed {
      logic take;     // capture the word straight into the held row
      logic load;     // capture the word as the new row
      logic commit;   // new row becomes the held row
      logic start;    // begin the slope division
      logic advance;  // step to the next interpolated row
   } lane_ctl_type;

endpackage

// ===== src/ugr_req_if.sv =====
interface ugr_req_if
   import ugr_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   command_type              command;
   logic signed [TIME_W-1:0] sample_time;
   logic signed [TIME_W-1:0] value_a;
   logic signed [TIME_W-1:0] value_b;
   logic signed [TIME_W-1:0] value_c;
   logic signed [TIME_W-1:0] value_d;

   modport source (output valid, command, sample_time, value_a, value_b, value_c, value_d,
                   input ready);
   modport sink (input valid, command, sample_time, value_a, value_b, value_c, value_d,
                 output ready);
endinterface

// ===== src/ugr_rsp_if.sv =====
interface ugr_rsp_if
   import ugr_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [GRID_W-1:0]        grid_index;
   logic signed [TIME_W-1:0] out_time;
   logic signed [TIME_W-1:0] out_a;
   logic signed [TIME_W-1:0] out_b;
   logic signed [TIME_W-1:0] out_c;
   logic signed [TIME_W-1:0] out_d;
   logic                     last;
   status_type               status;

   modport source (output valid, grid_index, out_time, out_a, out_b, out_c, out_d, last,
                   status, input ready);
   modport sink (input valid, grid_index, out_time, out_a, out_b, out_c, out_d, last,
                 status, output ready);
endinterface

// ===== src/uniform_grid_resampler.sv =====
// Channel   Dir  Contents
// req_bus   in   command, sample_time, value_a..value_d
// rsp_bus   out  grid_index, out_time, out_a..out_d, last, status
// csr_*     in   write enable, register index, write data (stride, num_values)
//
// One word is taken at a time. A data word after the first of a stream gets its grid index
// from the 35-step restoring divider; the second row first passes S_MUL and S_STEP for the step.
// A gap of one emits the held row and is done. Larger gaps wait for the slope division in
// the lanes, then pass through S_ADV and S_MID for each interpolated row. Reset is synchronous
// and active high. A stall on rsp_bus holds the current step; the output register lets the
// next word in meanwhile.
`include "uniform_grid_resampler_defines.svh"

module uniform_grid_resampler import ugr_pkg::*; #(
   parameter int MAX_VALUES = MAX_VALUES_DEF,
   parameter int MAX_GAP    = MAX_GAP_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ugr_req_if.sink               req_bus,
   ugr_rsp_if.source             rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Value columns that actually get a lane; the port carries four at most.
   localparam int VAL_LANES = (MAX_VALUES < VALUE_FIELDS) ? MAX_VALUES : VALUE_FIELDS;
   localparam int LANES     = VAL_LANES + 1;
   localparam int G_W       = $clog2(MAX_GAP + 1);
   localparam int IDX_NUM_W = TIME_W + 3;
   localparam int IDX_DEN_W = TIME_W + 2;
   localparam int PROD_W    = TIME_W + STRIDE_W + 2;
   localparam int WIDE_W    = TIME_W + 4;

   state_type                state_ff, state_in;
   rows_type                 rows_ff, rows_in;
   logic [STRIDE_W-1:0]      stride_ff;
   logic [NUMV_W-1:0]        numv_ff;
   logic signed [TIME_W-1:0] origin_ff, origin_in;
   logic signed [TIME_W-1:0] step_ff, step_in;
   logic signed [TIME_W-1:0] time_ff, time_in;
   logic [INDEX_BITS-1:0]    held_idx_ff, held_idx_in;
   logic [INDEX_BITS-1:0]    q_ff, q_in;
   logic [G_W-1:0]           gap_ff, gap_in;
   logic [G_W-1:0]           mid_ff, mid_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   status_type               err_ff, err_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [GRID_W-1:0]        rsp_grid_ff;
   logic signed [TIME_W-1:0] rsp_time_ff;
   logic signed [TIME_W-1:0] rsp_val_ff [VALUE_FIELDS];
   logic                     rsp_last_ff;
   status_type               rsp_status_ff;

   // Emission controls.
   logic                     emit;
   logic                     emit_err;
   logic                     emit_held;
   logic [INDEX_BITS-1:0]    emit_idx;
   logic                     emit_last;
   logic                     slot_free;

   lane_ctl_type             lane_ctl;
   logic signed [TIME_W-1:0] lane_in [LANES];
   logic signed [TIME_W-1:0] held_v [LANES];
   logic signed [TIME_W-1:0] mid_v [LANES];
   logic [LANES-1:0]         lane_rdy;
   logic                     lanes_ready;
   logic signed [TIME_W-1:0] fields [VALUE_FIELDS];
   logic signed [TIME_W-1:0] row_val [VALUE_FIELDS];
   logic [NUMV_W-1:0]        ncols;

   // Arithmetic of the step and index phases.
   logic signed [TIME_W:0]   delta;
   logic signed [WIDE_W-1:0] d_wide, s_wide, dm, sm, num;
   logic                     fits;
   logic signed [TIME_W-1:0] sat;
   logic                     div_start;
   logic                     div_done;
   logic [IDX_NUM_W-1:0]     div_q;
   logic [IDX_DEN_W-1:0]     div_r;
   logic [IDX_NUM_W-1:0]     gap_full;
   logic [G_W-1:0]           gap_start;

   assign fields[0] = req_bus.value_a;
   assign fields[1] = req_bus.value_b;
   assign fields[2] = req_bus.value_c;
   assign fields[3] = req_bus.value_d;

   assign ncols = (numv_ff > NUMV_W'(VAL_LANES)) ? NUMV_W'(VAL_LANES) : numv_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= STRIDE_RST;
         numv_ff   <= NUMV_RST;
      end else if (csr_write_enable) begin
         unique case (csr_type'(csr_index))
            CSR_STRIDE:     stride_ff <= csr_data[STRIDE_W-1:0];
            CSR_NUM_VALUES: numv_ff   <= csr_data[NUMV_W-1:0];
         endcase
      end
   end

   // Grid index divider, shared by every data word that needs a grid index.
   ugr_div #(.NUM_W(IDX_NUM_W), .DEN_W(IDX_DEN_W)) u_index_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numer     (num[IDX_NUM_W-1:0]),
      .denom     ({sm[IDX_DEN_W-2:0], 1'b0}),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Column lanes: lane zero carries time, the others the value columns.
   assign lane_in[0] = req_bus.sample_time;
   for (genvar k = 1; k < LANES; k++) begin : g_lane_in
      assign lane_in[k] = (NUMV_W'(k - 1) < ncols) ? fields[k-1] : '0;
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      ugr_lane #(.MAX_GAP(MAX_GAP)) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (lane_ctl),
         .in_value   (lane_in[k]),
         .gap        (gap_start),
         .held_value (held_v[k]),
         .mid_value  (mid_v[k]),
         .ready      (lane_rdy[k])
      );
   end

   assign lanes_ready = &lane_rdy;

   // Merge: pick held or interpolated values and blank the unused columns.
   for (genvar c = 0; c < VALUE_FIELDS; c++) begin : g_merge
      if (c < VAL_LANES) begin : g_used
         assign row_val[c] = (NUMV_W'(c) >= ncols) ? '0 :
                             (emit_held ? held_v[c+1] : mid_v[c+1]);
      end else begin : g_unused
         assign row_val[c] = '0;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign gap_full  = div_q - IDX_NUM_W'(held_idx_ff);
   assign gap_start = G_W'(gap_full);

   always_comb begin
      delta  = {time_ff[TIME_W-1], time_ff} - {origin_ff[TIME_W-1], origin_ff};
      d_wide = WIDE_W'(delta);
      s_wide = WIDE_W'(step_ff);
      // A negative step flips both operands so the divisor is positive.
      dm     = step_ff[TIME_W-1] ? -d_wide : d_wide;
      sm     = step_ff[TIME_W-1] ? -s_wide : s_wide;
      num    = (dm <<< 1) + sm;
      fits   = (prod_ff[PROD_W-1:TIME_W-1] == '0) || (prod_ff[PROD_W-1:TIME_W-1] == '1);
      sat    = fits ? prod_ff[TIME_W-1:0] :
               (prod_ff[PROD_W-1] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}});
   end

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      origin_in    = origin_ff;
      step_in      = step_ff;
      time_in      = time_ff;
      held_idx_in  = held_idx_ff;
      q_in         = q_ff;
      gap_in       = gap_ff;
      mid_in       = mid_ff;
      prod_in      = prod_ff;
      err_in       = err_ff;
      lane_ctl     = '0;
      div_start    = 1'b0;
      req_bus.ready = 1'b0;
      emit         = 1'b0;
      emit_err     = 1'b0;
      emit_held    = 1'b0;
      emit_idx     = held_idx_ff;
      emit_last    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               if (req_bus.command == CMD_FLUSH) begin
                  if (rows_ff != ROWS_NONE) begin
                     rows_in  = ROWS_NONE;
                     state_in = S_FLUSH;
                  end
               end else if (rows_ff == ROWS_NONE) begin
                  lane_ctl.take = 1'b1;
                  origin_in     = req_bus.sample_time;
                  held_idx_in   = '0;
                  rows_in       = ROWS_ORIGIN;
               end else begin
                  lane_ctl.load = 1'b1;
                  time_in       = req_bus.sample_time;
                  state_in      = (rows_ff == ROWS_ORIGIN) ? S_MUL : S_INDEX;
               end
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(delta) * PROD_W'($signed({1'b0, stride_ff}));
            state_in = S_STEP;
         end
         S_STEP: begin
            if (sat == '0) begin
               err_in   = ST_ZERO_STEP;
               state_in = S_ERR;
            end else begin
               step_in  = sat;
               rows_in  = ROWS_STEP;
               state_in = S_INDEX;
            end
         end
         S_INDEX: begin
            if (num[WIDE_W-1]) begin
               err_in   = ST_BACKWARD;
               state_in = S_ERR;
            end else begin
               div_start = 1'b1;
               state_in  = S_IDXW;
            end
         end
         S_IDXW: begin
            if (div_done) begin
               if (div_q < IDX_NUM_W'(held_idx_ff)) begin
                  err_in   = ST_BACKWARD;
                  state_in = S_ERR;
               end else if ((gap_full > IDX_NUM_W'(MAX_GAP)) ||
                            ((div_q >> INDEX_BITS) != '0)) begin
                  err_in   = ST_GAP;
                  state_in = S_ERR;
               end else if (gap_full == '0) begin
                  // Same grid row: the new word replaces the held one.
                  lane_ctl.commit = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  q_in           = INDEX_BITS'(div_q);
                  gap_in         = gap_start;
                  lane_ctl.start = 1'b1;
                  state_in       = S_HELD;
               end
            end
         end
         S_HELD: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_held = 1'b1;
               emit_last = (gap_ff == G_W'(1));
               if (gap_ff == G_W'(1)) begin
                  state_in = S_DONE;
               end else begin
                  mid_in   = G_W'(1);
                  state_in = S_ADV;
               end
            end
         end
         S_ADV: begin
            if (lanes_ready) begin
               lane_ctl.advance = 1'b1;
               state_in         = S_MID;
            end
         end
         S_MID: begin
            emit_idx = INDEX_BITS'(held_idx_ff + INDEX_BITS'(mid_ff));
            if (slot_free) begin
               emit      = 1'b1;
               emit_last = (mid_ff == gap_ff - G_W'(1));
               if (mid_ff == gap_ff - G_W'(1)) begin
                  state_in = S_DONE;
               end else begin
                  mid_in   = mid_ff + G_W'(1);
                  state_in = S_ADV;
               end
            end
         end
         S_DONE: begin
            lane_ctl.commit = 1'b1;
            held_idx_in     = q_ff;
            state_in        = S_IDLE;
         end
         S_ERR: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_err  = 1'b1;
               emit_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_held = 1'b1;
               emit_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_ff      <= ROWS_NONE;
         origin_ff    <= '0;
         step_ff      <= '0;
         held_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         origin_ff    <= origin_in;
         step_ff      <= step_in;
         held_idx_ff  <= held_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      time_ff <= time_in;
      q_ff    <= q_in;
      gap_ff  <= gap_in;
      mid_ff  <= mid_in;
      prod_ff <= prod_in;
      err_ff  <= err_in;
      if (emit) begin
         rsp_grid_ff   <= emit_err ? '0 : GRID_W'(emit_idx);
         rsp_time_ff   <= emit_err ? '0 : (emit_held ? held_v[0] : mid_v[0]);
         for (int c = 0; c < VALUE_FIELDS; c++) begin
            rsp_val_ff[c] <= emit_err ? '0 : row_val[c];
         end
         rsp_last_ff   <= emit_last;
         rsp_status_ff <= emit_err ? err_ff : ST_OK;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.grid_index = rsp_grid_ff;
   assign rsp_bus.out_time   = rsp_time_ff;
   assign rsp_bus.out_a      = rsp_val_ff[0];
   assign rsp_bus.out_b      = rsp_val_ff[1];
   assign rsp_bus.out_c      = rsp_val_ff[2];
   assign rsp_bus.out_d      = rsp_val_ff[3];
   assign rsp_bus.last       = rsp_last_ff;
   assign rsp_bus.status     = rsp_status_ff;

   // An error word always closes the results of its input word.
   `UGR_ASSERT_IMPLY(a_err_last, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK,
      rsp_last_ff, "error word without last")
   // Interpolated rows lie strictly between the held and the new grid row.
   `UGR_ASSERT_IMPLY(a_mid_range, clock, reset, state_ff == S_MID,
      mid_ff != '0 && mid_ff < gap_ff, "interpolation count out of range")
   // The held row of a gap is only emitted once the step is known.
   `UGR_ASSERT_IMPLY(a_held_step, clock, reset, state_ff == S_HELD,
      rows_ff == ROWS_STEP && gap_ff != '0, "held row emitted without a step")
   // A word left waiting is not overwritten.
   `UGR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_bus.ready,
      rsp_valid_ff && $stable(rsp_grid_ff) && $stable(rsp_last_ff), "result lost")

endmodule

// ===== src/ugr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ugr_div #(
   parameter int NUM_W = 35,
   parameter int DEN_W = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] diff;

   always_comb begin
      shifted  = {rem_ff, quo_ff[NUM_W-1]};
      diff     = {1'b0, shifted} - {2'b00, den_ff};
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         quo_in   = numer;
         rem_in   = '0;
         den_in   = denom;
         count_in = CNT_W'(NUM_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits DEN_W bits.
         rem_in   = diff[DEN_W+1] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
         quo_in   = {quo_ff[NUM_W-2:0], ~diff[DEN_W+1]};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/ugr_lane.sv =====
// One column: holds the held and new values and walks the interpolated rows
// with a quotient/remainder accumulator, so that only one division per row
// pair is needed.
module ugr_lane import ugr_pkg::*; #(
   parameter int MAX_GAP = MAX_GAP_DEF,
   localparam int G_W = $clog2(MAX_GAP + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctl_type             ctl,
   input  logic signed [TIME_W-1:0] in_value,
   input  logic [G_W-1:0]           gap,
   output logic signed [TIME_W-1:0] held_value,
   output logic signed [TIME_W-1:0] mid_value,
   output logic                     ready
);

   localparam int GAP_W  = G_W + 1;
   localparam int DIFF_W = TIME_W + 2;
   localparam int ACC_W  = TIME_W + 4;

   logic signed [TIME_W-1:0] held_ff, held_in;
   logic signed [TIME_W-1:0] new_ff, new_in;
   logic                     neg_ff, neg_in;
   logic [GAP_W-1:0]         g2_ff, g2_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [GAP_W-1:0]         rem_ff, rem_in;
   logic signed [ACC_W-1:0]  qd_ff, qd_in;
   logic [GAP_W-1:0]         rd_ff, rd_in;
   logic                     ready_ff, ready_in;

   logic signed [TIME_W:0]   delta;
   logic signed [DIFF_W-1:0] dbl;
   logic [DIFF_W-1:0]        mag;
   logic [GAP_W-1:0]         g2;
   logic                     div_done;
   logic [DIFF_W-1:0]        div_q;
   logic [GAP_W-1:0]         div_r;
   logic signed [ACC_W-1:0]  step_sum;
   logic [GAP_W:0]           rem_sum;

   ugr_div #(.NUM_W(DIFF_W), .DEN_W(GAP_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctl.start),
      .numer     (mag),
      .denom     (g2),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      delta    = {new_ff[TIME_W-1], new_ff} - {held_ff[TIME_W-1], held_ff};
      dbl      = {delta, 1'b0};
      mag      = dbl[DIFF_W-1] ? DIFF_W'(-dbl) : DIFF_W'(dbl);
      g2       = {gap, 1'b0};
      step_sum = acc_ff + qd_ff;
      rem_sum  = {1'b0, rem_ff} + {1'b0, rd_ff};

      held_in  = held_ff;
      new_in   = new_ff;
      neg_in   = neg_ff;
      g2_in    = g2_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      qd_in    = qd_ff;
      rd_in    = rd_ff;
      ready_in = ready_ff;

      if (ctl.take) begin
         held_in = in_value;
      end
      if (ctl.load) begin
         new_in = in_value;
      end
      if (ctl.commit) begin
         held_in = new_ff;
      end
      if (ctl.start) begin
         // Row zero is the held value with remainder g out of 2g.
         acc_in   = ACC_W'(held_ff);
         rem_in   = GAP_W'(gap);
         g2_in    = g2;
         neg_in   = dbl[DIFF_W-1];
         ready_in = 1'b0;
      end
      if (div_done) begin
         // Turn the magnitude division into a floor division of the slope.
         if (neg_ff) begin
            if (div_r != '0) begin
               qd_in = -ACC_W'(div_q) - ACC_W'(1);
               rd_in = g2_ff - div_r;
            end else begin
               qd_in = -ACC_W'(div_q);
               rd_in = '0;
            end
         end else begin
            qd_in = ACC_W'(div_q);
            rd_in = div_r;
         end
         ready_in = 1'b1;
      end
      if (ctl.advance) begin
         if (rem_sum >= {1'b0, g2_ff}) begin
            acc_in = step_sum + ACC_W'(1);
            rem_in = GAP_W'(rem_sum - {1'b0, g2_ff});
         end else begin
            acc_in = step_sum;
            rem_in = rem_sum[GAP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
      end else begin
         ready_ff <= ready_in;
      end
      held_ff <= held_in;
      new_ff  <= new_in;
      neg_ff  <= neg_in;
      g2_ff   <= g2_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      qd_ff   <= qd_in;
      rd_ff   <= rd_in;
   end

   assign held_value = held_ff;
   assign mid_value  = acc_ff[TIME_W-1:0];
   assign ready      = ready_ff;

endmodule

// ===== verif/testbench.sv =====
module testbench import ugr_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // One word offered on the request channel.
   typedef struct {
      command_type       cmd;
      logic signed [31:0] stamp;
      logic signed [31:0] vals [4];
   } row_word_type;

   // One grid row as it should appear on the response channel.
   typedef struct {
      logic [GRID_W-1:0]  idx;
      logic signed [31:0] stamp;
      logic signed [31:0] vals [4];
      logic               last;
      status_type         status;
   } grid_row_type;

   localparam int  QUIET_LIMIT = 5000;  // cycles with no accepted word on either side
   localparam int  SETTLE      = 120;   // longest time the block may still be busy
   localparam int  GAP_LIMIT   = 16;
   localparam longint IDX_MAX  = (longint'(1) << 20) - 1;

   logic clock;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   ugr_req_if req ();
   ugr_rsp_if rsp ();

   uniform_grid_resampler DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req),
      .rsp_bus          (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Free-running 50 MHz clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Shadow copy of the resampler: configuration and stream state.
   int unsigned stride_cfg;
   int unsigned columns_cfg;
   int          rows_known;
   longint      origin_stamp;
   longint      step_size;
   longint      held_idx;
   longint      held_cols [5];

   grid_row_type expected_rows [$];
   int      failures;
   bit      gaps_on;
   int      quiet_cycles;

   function automatic longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic int columns_in_use();
      return (columns_cfg > 4) ? 4 : int'(columns_cfg);
   endfunction

   // Queue one grid row; columns beyond the configured count read as zero.
   task automatic emit_row(longint idx, longint cols [5], bit last);
      grid_row_type r;
      int      n;
      n = columns_in_use();
      r.idx    = idx[GRID_W-1:0];
      r.stamp  = cols[0][31:0];
      for (int c = 0; c < 4; c++) r.vals[c] = (c < n) ? cols[c+1][31:0] : 32'sd0;
      r.last   = last;
      r.status = ST_OK;
      expected_rows.insert(expected_rows.size(), r);
   endtask

   // Error results carry only a status and a set last flag.
   task automatic emit_error(status_type code);
      grid_row_type r;
      r.idx    = '0;
      r.stamp  = '0;
      for (int c = 0; c < 4; c++) r.vals[c] = '0;
      r.last   = 1'b1;
      r.status = code;
      expected_rows.insert(expected_rows.size(), r);
   endtask

   // Work out the grid rows that one accepted word produces.
   task automatic resample_word(row_word_type w);
      longint cols [5];
      longint mid [5];
      longint d, s, num, q, g, st;
      int     n;
      n = columns_in_use();
      if (w.cmd == CMD_FLUSH) begin
         if (rows_known == 0) return;
         emit_row(held_idx, held_cols, 1'b1);
         rows_known = 0;
         return;
      end
      for (int c = 0; c < 5; c++) cols[c] = 0;
      cols[0] = longint'(w.stamp);
      for (int c = 0; c < n; c++) cols[c+1] = longint'(w.vals[c]);

      if (rows_known == 0) begin
         // The first row of a stream fixes the origin and becomes the held row.
         origin_stamp = cols[0];
         held_idx     = 0;
         held_cols    = cols;
         rows_known   = 1;
         return;
      end
      if (rows_known == 1) begin
         // The second row sets the step, saturated to the signed 32-bit range.
         st = (cols[0] - held_cols[0]) * longint'(stride_cfg);
         if (st > 64'sd2147483647) st = 64'sd2147483647;
         if (st < -64'sd2147483648) st = -64'sd2147483648;
         if (st == 0) begin
            emit_error(ST_ZERO_STEP);
            return;
         end
         step_size  = st;
         rows_known = 2;
      end

      d = cols[0] - origin_stamp;
      s = step_size;
      if (s < 0) begin
         d = -d;
         s = -s;
      end
      num = 2 * d + s;
      if (num < 0) begin
         emit_error(ST_BACKWARD);
         return;
      end
      q = num / (2 * s);
      if (q < held_idx) begin
         emit_error(ST_BACKWARD);
         return;
      end
      g = q - held_idx;
      if (g > GAP_LIMIT || q > IDX_MAX) begin
         emit_error(ST_GAP);
         return;
      end
      if (g == 0) begin
         held_cols = cols;
         return;
      end

      // The held row goes out first, then every row strictly in between.
      emit_row(held_idx, held_cols, g == 1);
      for (longint i = 1; i < g; i++) begin
         for (int c = 0; c < 5; c++) begin
            mid[c] = (c <= n)
               ? floor_quot(2 * (held_cols[c] * (g - i) + cols[c] * i) + g, 2 * g) : 0;
         end
         emit_row(held_idx + i, mid, i + 1 == g);
      end
      held_idx  = q;
      held_cols = cols;
   endtask

   // Offer one word and hold it until the block takes it. The valid line is left
   // high so that back-to-back words need no second assignment in one step.
   task automatic send_word(command_type cmd, longint stamp, logic [31:0] a,
                            logic [31:0] b, logic [31:0] c, logic [31:0] d);
      row_word_type w;
      w.cmd     = cmd;
      w.stamp   = stamp[31:0];
      w.vals[0] = a;
      w.vals[1] = b;
      w.vals[2] = c;
      w.vals[3] = d;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.command     <= cmd;
      req.sample_time <= w.stamp;
      req.value_a     <= a;
      req.value_b     <= b;
      req.value_c     <= c;
      req.value_d     <= d;
      do @(posedge clock); while (!req.ready);
      resample_word(w);
   endtask

   task automatic send_row(longint stamp);
      send_word(CMD_DATA, stamp, $urandom(), $urandom(), $urandom(), $urandom());
   endtask

   task automatic send_flush();
      send_word(CMD_FLUSH, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
   endtask

   // Drop valid, wait for every expected row, then let the block settle, since
   // a word that produced nothing may still be in the divider.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle. The enable is high for a single
   // cycle per write and drops between writes, so that two writes never share a time step.
   task automatic write_reg(csr_type idx, int unsigned value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_STRIDE) stride_cfg = value & 32'h7FF;
      else columns_cfg = value & 32'h7;
      @(posedge clock);
   endtask

   task automatic configure(int unsigned stride, int unsigned columns);
      write_reg(CSR_STRIDE, stride);
      write_reg(CSR_NUM_VALUES, columns);
   endtask

   // A well-formed stream: origin, step row, then rows that mostly advance a few
   // grid rows with jitter below half a step. A few rows jump too far or go
   // backward, and most streams end with a flush.
   task automatic run_stream(int rows);
      longint base, dt, step, k, adv, jitter, half;
      base = longint'($signed($urandom()));
      dt   = $urandom_range(1, 3000);
      if ($urandom_range(0, 1)) dt = -dt;
      send_row(base);
      send_row(base + dt);
      step = dt * stride_cfg;
      half = (step < 0 ? -step : step) / 2;
      k    = 0;
      for (int r = 2; r < rows; r++) begin
         case ($urandom_range(0, 19))
            0:       adv = -longint'($urandom_range(1, 3));
            1:       adv = $urandom_range(17, 20);
            2, 3:    adv = $urandom_range(5, 16);
            default: adv = $urandom_range(0, 4);
         endcase
         k      = k + adv;
         jitter = (half > 1) ? longint'($urandom_range(0, 2 * half - 2)) - half + 1 : 0;
         send_row(base + k * step + jitter);
         if (adv > 16 || adv < 0) k = k - adv;
      end
      if ($urandom_range(0, 9) != 0) send_flush();
   endtask

   // Edge cases at the reset setting: empty flush, zero step, rounding on a
   // half step, a gap of 14 rows, one gap too many, a backward row, full-scale
   // times and values, and a flush that restarts the stream.
   task automatic test_edge_cases();
      send_flush();
      send_word(CMD_DATA, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(CMD_DATA, 0, 32'h1, 32'h2, 32'h3, 32'h4);
      send_word(CMD_DATA, 100, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_row(150);
      send_row(250);
      send_word(CMD_DATA, 1700, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_row(1800);
      send_row(3500);
      send_row(1200);
      send_row(-50);
      send_flush();
      send_flush();
      send_word(CMD_DATA, 32'sh8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
      send_word(CMD_DATA, 32'sh7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF);
      send_row(32'sh7FFF_FFFF);
      send_flush();
      send_row(-1000);
      send_row(-1300);
      send_row(-2500);
      send_flush();
      drain();
   endtask

   // A zero stride makes every row after the first of a stream a zero-step error.
   task automatic test_zero_stride();
      configure(0, 2);
      run_stream(5);
      send_flush();
      drain();
   endtask

   // Random streams across several register settings, extremes included.
   task automatic test_streams();
      int unsigned strides [6] = '{1024, 1, 2, 3, 7, 1};
      int unsigned cols    [6] = '{0, 4, 7, 1, 3, 2};
      for (int p = 0; p < 6; p++) begin
         configure(strides[p], cols[p]);
         for (int s = 0; s < 4; s++) run_stream($urandom_range(3, 12));
         drain();
      end
   endtask

   // Unstructured words: random times and commands, mostly garbage streams.
   task automatic test_noise();
      configure($urandom_range(1, 1024), $urandom_range(0, 7));
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(0, 5) == 0) send_flush();
         else send_row(longint'($signed($urandom())) >>> $urandom_range(0, 24));
      end
      send_flush();
      drain();
   endtask

   // The last part runs with no idling on either side.
   task automatic test_full_rate();
      gaps_on = 1'b0;
      configure(1, 4);
      for (int s = 0; s < 6; s++) run_stream($urandom_range(4, 12));
      send_flush();
      drain();
   endtask

   // Response side: accept a row, compare every field with the oldest
   // expectation, and pick the next ready value in the same step.
   int stall_left;
   always @(posedge clock) begin
      grid_row_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rows.size() == 0) begin
            $error("unexpected row: index %0d status %0d", rsp.grid_index, rsp.status);
            failures++;
         end else begin
            e = expected_rows.pop_front();
            if (rsp.grid_index !== e.idx) begin
               $error("grid_index: expected %0d, got %0d", e.idx, rsp.grid_index);
               failures++;
            end
            if (rsp.out_time !== e.stamp) begin
               $error("out_time: expected %0d, got %0d", e.stamp, rsp.out_time);
               failures++;
            end
            if (rsp.out_a !== e.vals[0]) begin
               $error("out_a: expected %0d, got %0d", e.vals[0], rsp.out_a);
               failures++;
            end
            if (rsp.out_b !== e.vals[1]) begin
               $error("out_b: expected %0d, got %0d", e.vals[1], rsp.out_b);
               failures++;
            end
            if (rsp.out_c !== e.vals[2]) begin
               $error("out_c: expected %0d, got %0d", e.vals[2], rsp.out_c);
               failures++;
            end
            if (rsp.out_d !== e.vals[3]) begin
               $error("out_d: expected %0d, got %0d", e.vals[3], rsp.out_d);
               failures++;
            end
            if (rsp.last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp.last);
               failures++;
            end
            if (rsp.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp.status);
               failures++;
            end
         end
      end
      if (stall_left == 0 && gaps_on && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 8);
      rsp.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
   end

   // Watchdog: a long stretch with no word moving on either channel is a hang.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      failures     = 0;
      quiet_cycles = 0;
      stall_left   = 0;
      gaps_on      = 1'b1;
      stride_cfg   = 1;
      columns_cfg  = 4;
      rows_known   = 0;
      origin_stamp = 0;
      step_size    = 0;
      held_idx     = 0;
      for (int c = 0; c < 5; c++) held_cols[c] = 0;

      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_STRIDE;
      csr_data         <= '0;
      req.valid        <= 1'b0;
      req.command      <= CMD_DATA;
      req.sample_time  <= '0;
      req.value_a      <= '0;
      req.value_b      <= '0;
      req.value_c      <= '0;
      req.value_d      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_cases();
      test_zero_stride();
      test_streams();
      test_noise();
      test_full_rate();

      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/ugr_pkg.sv
src/ugr_req_if.sv
src/ugr_rsp_if.sv
src/ugr_div.sv
src/ugr_lane.sv
src/uniform_grid_resampler.sv
verif/testbench.sv
